FILE: rtl/sha256_single_block_hash_top_macros.svh
// Assertion helpers shared by the block's modules.
`ifndef SHA256_SINGLE_BLOCK_HASH_TOP_MACROS_SVH
`define SHA256_SINGLE_BLOCK_HASH_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        too_long;
	} sha_out_t;

	localparam int unsigned MsgLimit = 56;

	localparam logic [7:0] PadByte = 8'b1000_0000;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	// Control from the sequencer to the schedule memory.
	typedef struct packed {
		logic        wr_en;
		logic [3:0]  wr_addr;
		logic [31:0] wr_data;
		logic [3:0]  rd_addr;
	} sha_sched_req_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

FILE: rtl/sha_sched_mem.sv
`timescale 1ns / 1ps
`include "sha256_single_block_hash_top_macros.svh"
module sha_sched_mem import sha_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  sha_sched_req_t req,
	output logic [31:0]    rd_data
);
	// Sixteen-word schedule window, one write and one registered read a cycle.
	logic [31:0] mem_q [16];
	logic [3:0]  last_wr_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_data <= mem_q[req.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_wr_q <= '0;
		end else if (req.wr_en) begin
			last_wr_q <= req.wr_addr;
		end
	end

	`SHA_ASSERT_NEXT(a_wr_addr_held, req.wr_en, last_wr_q == $past(req.wr_addr), "write address lost")
	`SHA_ASSERT_IMP(a_wr_known, req.wr_en, !$isunknown(req.wr_addr), "unknown write address")
	`SHA_ASSERT_IMP(a_rd_known, arst_n, !$isunknown(req.rd_addr), "unknown read address")
endmodule

FILE: rtl/sha_core.sv
`timescale 1ns / 1ps
`include "sha256_single_block_hash_top_macros.svh"
module sha_core import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  sha_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output sha_out_t out_data
);
	typedef enum logic [2:0] {
		ST_LOAD, ST_PACK, ST_RND_RD, ST_RND, ST_EMIT, ST_ERR
	} state_t;

	state_t         state_q;
	logic [7:0]     msg_q [MsgLimit];
	logic [7:0]     msg_rd_q;
	logic [5:0]     count_q;
	logic           ovf_q;
	logic [6:0]     step_q;
	logic [1:0]     sub_q;
	logic [31:0]    word_q;
	logic [31:0]    w15_q;
	logic [31:0]    w2_q;
	logic [31:0]    w7_q;
	logic [31:0]    va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q;
	logic [3:0]     emit_q;
	sha_sched_req_t sreq;
	logic [31:0]    sdata;
	logic [5:0]     msg_rd_addr;

	sha_sched_mem u_sched (.clk(clk), .arst_n(arst_n), .req(sreq), .rd_data(sdata));

	assign in_stall = (state_q != ST_LOAD);

	// Message byte memory, read one byte a cycle while packing words.
	logic [5:0] pack_byte;
	assign pack_byte = {step_q[3:0], sub_q};
	assign msg_rd_addr = (pack_byte < 6'(MsgLimit)) ? pack_byte : 6'd0;

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && in_valid && in_data.byte_valid && !ovf_q) begin
			msg_q[count_q] <= in_data.data_byte;
		end
		msg_rd_q <= msg_q[msg_rd_addr];
	end

	// Padded block byte for the byte read last cycle (address pb).
	function automatic logic [7:0] blk_byte(input logic [5:0] pb, input logic [7:0] mb,
		input logic [5:0] cnt);
		logic [8:0] bits;
		bits = {cnt, 3'b000};
		if (pb < cnt) blk_byte = mb;
		else if (pb == cnt) blk_byte = PadByte;
		else if (pb == 6'd62) blk_byte = {7'd0, bits[8]};
		else if (pb == 6'd63) blk_byte = bits[7:0];
		else blk_byte = 8'd0;
	endfunction

	logic [5:0]  prev_byte;
	logic [31:0] packed_w;
	logic [31:0] ws0, ws1, wnew, t1, t2, cur_w;
	logic [6:0]  r;

	always_comb begin
		prev_byte = pack_byte - 6'd1;
		packed_w = {word_q[23:0], blk_byte(prev_byte, msg_rd_q, count_q)};
		r = step_q;
		ws0 = rotr(w15_q, 7) ^ rotr(w15_q, 18) ^ (w15_q >> 3);
		ws1 = rotr(w2_q, 17) ^ rotr(w2_q, 19) ^ (w2_q >> 10);
		wnew = sdata + ws0 + w7_q + ws1;
		cur_w = (r < 7'd16) ? sdata : wnew;
		t1 = vh_q + (rotr(ve_q, 6) ^ rotr(ve_q, 11) ^ rotr(ve_q, 25))
			+ ((ve_q & vf_q) ^ (~ve_q & vg_q)) + RoundK[r[5:0]] + cur_w;
		t2 = (rotr(va_q, 2) ^ rotr(va_q, 13) ^ rotr(va_q, 22))
			+ ((va_q & vb_q) ^ (va_q & vc_q) ^ (vb_q & vc_q));
		sreq = '0;
		case (state_q)
			ST_PACK: begin
				sreq.wr_en   = (sub_q == 2'd0) && (step_q != 7'd0);
				sreq.wr_addr = step_q[3:0] - 4'd1;
				sreq.wr_data = packed_w;
			end
			ST_RND_RD: begin
				// Operand fetch: w[r-15], w[r-2], w[r-7], then w[r-16] (w[r] in rounds 0 to 15).
				case (sub_q)
					2'd0: sreq.rd_addr = r[3:0] + 4'd1;
					2'd1: sreq.rd_addr = r[3:0] + 4'd14;
					2'd2: sreq.rd_addr = r[3:0] + 4'd9;
					default: sreq.rd_addr = r[3:0];
				endcase
			end
			ST_RND: begin
				sreq.wr_en   = (r >= 7'd16);
				sreq.wr_addr = r[3:0];
				sreq.wr_data = wnew;
			end
			default: ;
		endcase
	end

	logic [31:0] dig;
	always_comb begin
		case (emit_q[2:0])
			3'd0: dig = va_q; 3'd1: dig = vb_q; 3'd2: dig = vc_q; 3'd3: dig = vd_q;
			3'd4: dig = ve_q; 3'd5: dig = vf_q; 3'd6: dig = vg_q; default: dig = vh_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD; count_q <= '0; ovf_q <= 1'b0; step_q <= '0;
			sub_q <= '0; emit_q <= '0; out_valid <= 1'b0; out_data <= '0;
		end else begin
			case (state_q)
				ST_LOAD: if (in_valid) begin
					logic [5:0] nc;
					nc = count_q;
					if (in_data.byte_valid && !ovf_q) begin
						nc = count_q + 6'd1;
						count_q <= nc;
						if (nc == 6'(MsgLimit)) ovf_q <= 1'b1;
					end
					if (in_data.end_of_message) begin
						if (ovf_q || nc == 6'(MsgLimit)) begin
							state_q <= ST_ERR;
							out_valid <= 1'b1;
							out_data <= '{digest_word: '0, word_index: '0,
								last_word: 1'b1, too_long: 1'b1};
						end else begin
							state_q <= ST_PACK;
							step_q <= '0; sub_q <= '0;
						end
					end
				end
				ST_ERR: if (!out_stall) begin
					out_valid <= 1'b0; state_q <= ST_LOAD; count_q <= '0; ovf_q <= 1'b0;
				end
				ST_PACK: begin
					if (step_q != 7'd0 || sub_q != 2'd0) word_q <= packed_w;
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) step_q <= step_q + 7'd1;
					if (step_q == 7'd16) begin
						step_q <= '0; sub_q <= '0; state_q <= ST_RND_RD;
						va_q <= InitHash[0]; vb_q <= InitHash[1];
						vc_q <= InitHash[2]; vd_q <= InitHash[3];
						ve_q <= InitHash[4]; vf_q <= InitHash[5];
						vg_q <= InitHash[6]; vh_q <= InitHash[7];
					end
				end
				ST_RND_RD: begin
					// Data for address issued last cycle arrives now.
					case (sub_q)
						2'd1: w15_q <= sdata;
						2'd2: w2_q <= sdata;
						2'd3: w7_q <= sdata;
						default: ;
					endcase
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) state_q <= ST_RND;
				end
				ST_RND: begin
					vh_q <= vg_q; vg_q <= vf_q; vf_q <= ve_q; ve_q <= vd_q + t1;
					vd_q <= vc_q; vc_q <= vb_q; vb_q <= va_q; va_q <= t1 + t2;
					sub_q <= '0;
					if (r == 7'd63) begin
						state_q <= ST_EMIT; emit_q <= '0; step_q <= '0;
					end else begin
						step_q <= r + 7'd1; state_q <= ST_RND_RD;
					end
				end
				ST_EMIT: begin
					if (!out_valid || !out_stall) begin
						if (emit_q == 4'd8) begin
							out_valid <= 1'b0; state_q <= ST_LOAD;
							count_q <= '0; ovf_q <= 1'b0;
						end else begin
							out_valid <= 1'b1;
							out_data <= '{digest_word: dig + InitHash[emit_q[2:0]],
								word_index: emit_q[2:0], last_word: emit_q == 4'd7,
								too_long: 1'b0};
							emit_q <= emit_q + 4'd1;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	`SHA_ASSERT_IMP(a_stall_busy, state_q != ST_LOAD, in_stall, "input taken while busy")
	`SHA_ASSERT_IMP(a_count_lim, 1'b1, count_q <= 6'(MsgLimit), "byte count past limit")
	`SHA_ASSERT_IMP(a_err_last, out_valid && out_data.too_long, out_data.last_word, "error not last")
	`SHA_ASSERT_IMP(a_rounds, state_q == ST_RND, step_q < 7'd64, "round index out of range")
endmodule

FILE: rtl/sha256_single_block_hash_top.sv
`timescale 1ns / 1ps
// Single-block SHA-256 hasher.
// Input channel (in_valid/in_stall/in_data): one request per message byte;
// byte_valid 0 makes an empty request, end_of_message closes the message.
// Bytes are taken one per cycle; in_stall stays low while gathering bytes.
// After the end mark in_stall rises while the block is packed into the
// sixteen-word schedule memory and 64 rounds run, each on the schedule
// memory's one read port as four reads and a compute/write-back.
// Output channel (out_valid/out_stall/out_data): eight digest words, H0
// first, last_word set on word 7, one per cycle when not stalled.
// A message of 56 bytes or more yields one result with too_long set, offered
// the cycle after the end mark is taken.
// Input is taken again the cycle after the last result is taken.
// While out_stall is high the current word holds and the block waits.
// Asynchronous reset (arst_n low) returns the block to byte gathering with
// an empty message; the memories keep no reset value.
module sha256_single_block_hash_top import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  sha_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output sha_out_t out_data
);
	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import sha_pkg::*;

	localparam int unsigned IdleLimit = 20000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	sha_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	sha_out_t out_data;

	bit failed;
	bit hold_off;
	bit stim_done;
	int unsigned quiet_cycles;

	sha256_single_block_hash_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	class digest_scoreboard;
		logic [7:0] msg_buf [56];
		int unsigned msg_len;
		bit overflow;
		sha_out_t pending [$];
		int unsigned mismatches;

		function logic [31:0] ror(logic [31:0] x, int unsigned n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void hash_message();
			logic [7:0] blk [64];
			logic [31:0] w [64];
			logic [31:0] v [8];
			logic [31:0] t1, t2;
			logic [63:0] bit_len;
			sha_out_t res;
			bit_len = 64'(msg_len) * 8;
			for (int i = 0; i < 64; i++) blk[i] = 8'h00;
			for (int i = 0; i < msg_len; i++) blk[i] = msg_buf[i];
			blk[msg_len] = PadByte;
			for (int i = 0; i < 8; i++) blk[63 - i] = bit_len[8 * i +: 8];
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
			for (int i = 16; i < 64; i++)
				w[i] = w[i - 16] + w[i - 7]
					+ (ror(w[i - 15], 7) ^ ror(w[i - 15], 18) ^ (w[i - 15] >> 3))
					+ (ror(w[i - 2], 17) ^ ror(w[i - 2], 19) ^ (w[i - 2] >> 10));
			for (int i = 0; i < 8; i++) v[i] = InitHash[i];
			for (int r = 0; r < 64; r++) begin
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int k = 0; k < 8; k++) begin
				res.digest_word = InitHash[k] + v[k];
				res.word_index = 3'(k);
				res.last_word = (k == 7);
				res.too_long = 1'b0;
				pending.push_back(res);
			end
		endfunction

		function void note_request(sha_in_t req);
			sha_out_t res;
			if (req.byte_valid && !overflow && msg_len < MsgLimit) begin
				msg_buf[msg_len] = req.data_byte;
				msg_len++;
				if (msg_len >= MsgLimit) overflow = 1;
			end
			if (req.end_of_message) begin
				if (overflow) begin
					res = '0;
					res.last_word = 1'b1;
					res.too_long = 1'b1;
					pending.push_back(res);
				end else begin
					hash_message();
				end
				msg_len = 0;
				overflow = 0;
			end
		endfunction

		function void check_word(sha_out_t got);
			sha_out_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				mismatches++;
				return;
			end
			exp = pending.pop_front();
			if (got.digest_word !== exp.digest_word)
				$display("%0t: digest_word expected %h actual %h", $time,
					exp.digest_word, got.digest_word);
			if (got.word_index !== exp.word_index)
				$display("%0t: word_index expected %0d actual %0d", $time,
					exp.word_index, got.word_index);
			if (got.last_word !== exp.last_word)
				$display("%0t: last_word expected %b actual %b", $time,
					exp.last_word, got.last_word);
			if (got.too_long !== exp.too_long)
				$display("%0t: too_long expected %b actual %b", $time,
					exp.too_long, got.too_long);
			if (got !== exp) mismatches++;
		endfunction
	endclass

	digest_scoreboard sb;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Idle odds per side, in percent; zero during the calm stretch.
	int unsigned idle_pct;

	// The request stays offered after it is taken; the next call replaces it.
	task automatic send_request(logic [7:0] data, bit bv, bit eom);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: data, byte_valid: bv, end_of_message: eom};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_message(int unsigned len, bit with_empties, bit empty_end);
		for (int i = 0; i < len; i++) begin
			if (with_empties && $urandom_range(7) == 0)
				send_request(8'($urandom), 1'b0, 1'b0);
			send_request(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
		end
		if (empty_end || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
	endtask

	// One edge first so the request taken last is already noted.
	task automatic wait_drained();
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sb.note_request(in_data);
			quiet_cycles <= 0;
		end else if (out_valid && !out_stall) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (out_valid && !out_stall) sb.check_word(out_data);
		if (quiet_cycles > IdleLimit) begin
			$display("[sha256_single_block_hash_top] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
	end

	// Long receiver hold-off so the block fills and stalls its input.
	initial begin
		hold_off = 1'b0;
		wait (stim_done == 1'b0 && arst_n);
		repeat (300) @(posedge clk);
		hold_off = 1'b1;
		repeat (1500) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		sb = new();
		failed = 1'b0;
		stim_done = 1'b0;
		quiet_cycles = 0;
		idle_pct = 10;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, empty end item, extremes, limits.
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'h00, 1'b1, 1'b1);
		send_request(8'hff, 1'b1, 1'b1);
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
		send_message(55, 1'b0, 1'b0);
		// The last byte arrives after the limit and is dropped.
		send_message(57, 1'b0, 1'b0);
		// The sender pauses until every digest word is back.
		in_valid <= 1'b0;
		wait_drained();

		// Calm stretch: no idling on either side.
		idle_pct = 0;
		for (int m = 0; m < 4; m++)
			send_message($urandom_range(1, 4), 1'b0, 1'b0);
		idle_pct = 10;

		for (int m = 0; m < 6; m++)
			send_message($urandom_range(0, 5), 1'b1, $urandom_range(1));
		in_valid <= 1'b0;
		stim_done = 1'b1;

		wait_drained();
		repeat (500) @(posedge clk);
		if (!failed && sb.mismatches == 0 && sb.pending.size() == 0)
			$display("[sha256_single_block_hash_top] OK");
		else
			$display("[sha256_single_block_hash_top] ERROR");
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha_sched_mem.sv
rtl/sha_core.sv
rtl/sha256_single_block_hash_top.sv
tb/tb_top.sv
